[hw/rtl/mel_run_length_encoder_core_macros.svh]
// Assertion macros shared by the checker of the MEL run-length encoder.
// No dependencies; included by files that assert.
`ifndef MEL_RUN_LENGTH_ENCODER_CORE_MACROS_SVH
`define MEL_RUN_LENGTH_ENCODER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define MEL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define MEL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/mel_rle_pkg.sv]
// Package of the MEL run-length encoder: item types, queue entry and constants.
// No dependencies.
package mel_rle_pkg;

  localparam int CountW     = 24;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [3:0] MaxIndex = 4'd8;
  localparam logic [CountW-1:0] MaxBytesReset = {CountW{1'b1}};

  // request codes
  localparam logic ReqSymbol = 1'b0;
  localparam logic ReqFlush  = 1'b1;

  // threshold exponent per state index
  localparam logic [1:0] ExpTable [0:8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1,
                                             2'd2, 2'd2, 2'd3, 2'd3};

  typedef struct packed {
    logic req_type;
    logic sig;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              has_byte;
    logic              is_last;
    logic              overflow;
    logic [CountW-1:0] total_bytes;
  } out_item_t;

  // job handed from packer to byte stage
  typedef struct packed {
    logic [7:0] data0;
    logic [7:0] data1;
    logic [1:0] nbytes;
    logic       flush;
  } job_t;

endpackage

[hw/rtl/mel_run_length_encoder_core.sv]
// Top level of the adaptive MEL run-length encoder.
// Depends on mel_rle_pkg, mel_rle_front, mel_rle_fifo, mel_rle_back.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-------------------------------
//   in      | sink      | valid_i / stall_o | in_item_t (req_type, sig)
//   out     | source    | valid_o / stall_i | out_item_t (byte, flags, count)
//   cfg     | sink      | valid_i / ready_o | max_bytes, 24 bit
//
// One item per cycle enters the packer while the job queue is not full; a
// symbol leaves at most one result, a flush up to two. The byte stage handles
// one job half per cycle while the output is not stalled, so a flush carrying
// two bytes holds it for both halves while the packer carries on. A result
// passes the job queue and then waits in the output register until taken.
// in_stall_o rises only when the four-entry job queue is full.
// Reset leaves all coding state at zero and max_bytes at its full value.
module mel_run_length_encoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mel_rle_pkg::in_item_t             in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mel_rle_pkg::out_item_t            out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mel_rle_pkg::CountW-1:0]    cfg_data_i
);

  // byte limit register; the user must write it only while the block is idle, the block does not enforce it
  logic [mel_rle_pkg::CountW-1:0] max_bytes_q;

  // packer to queue
  logic              push;
  mel_rle_pkg::job_t job;
  logic              q_full;

  // queue to byte stage
  logic              head_valid;
  mel_rle_pkg::job_t head;
  logic              pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= mel_rle_pkg::MaxBytesReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_bytes_q <= cfg_data_i;
    end
  end

  // front: run counting, index adaptation and byte assembly
  mel_rle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .job_o      (job),
    .q_full_i   (q_full)
  );

  // decoupling queue; a job holds every byte one item completes
  mel_rle_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // back: byte limit, sticky overflow and block end marker
  mel_rle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .max_bytes_i  (max_bytes_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

[hw/rtl/mel_rle_front.sv]
// Front end of the MEL encoder: run tracking, state adaptation and bit packing.
// Depends on mel_rle_pkg.
module mel_rle_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mel_rle_pkg::in_item_t in_item_i,
  output logic                  push_o,
  output mel_rle_pkg::job_t     job_o,
  input  logic                  q_full_i
);

  logic [3:0] idx_q, idx_d;
  logic [2:0] run_q, run_d;
  logic [7:0] acc_q, acc_d;
  logic [2:0] fill_q, fill_d;

  logic        accept;
  logic        is_flush;
  logic [1:0]  k;
  logic [2:0]  n;
  logic [3:0]  bits;
  logic [2:0]  run_inc;
  logic [2:0]  run_lim;
  logic [11:0] wide;
  logic [3:0]  total;
  logic [2:0]  rem;
  logic        done;
  logic [7:0]  cbyte;
  logic [7:0]  acc_n;
  logic [2:0]  fill_n;
  logic        pad;
  logic [7:0]  pad_byte;
  logic [2:0]  kmask;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_flush   = (in_item_i.req_type == mel_rle_pkg::ReqFlush);
  assign k          = mel_rle_pkg::ExpTable[idx_q];
  assign kmask      = 3'((4'd1 << k) - 4'd1);
  assign run_inc    = run_q + 3'd1;
  assign run_lim    = 3'((4'd1 << k));

  // bits to append this item and the next run/index
  always_comb begin
    n     = 3'd0;
    bits  = 4'd0;
    run_d = run_q;
    idx_d = idx_q;
    if (is_flush) begin
      if (run_q != 3'd0) begin
        n    = {1'b0, k} + 3'd1;
        bits = {1'b0, run_q & kmask};
      end
      run_d = 3'd0;
      idx_d = 4'd0;
    end else if (!in_item_i.sig) begin
      if (run_inc == run_lim) begin
        n     = 3'd1;
        bits  = 4'd1;
        run_d = 3'd0;
        if (idx_q < mel_rle_pkg::MaxIndex) begin
          idx_d = idx_q + 4'd1;
        end
      end else begin
        run_d = run_inc;
      end
    end else begin
      n     = {1'b0, k} + 3'd1;
      bits  = {1'b0, run_q & kmask};
      run_d = 3'd0;
      if (idx_q != 4'd0) begin
        idx_d = idx_q - 4'd1;
      end
    end
  end

  // MSB-first packing; at most one byte completes
  always_comb begin
    wide  = ({4'd0, acc_q} << n) | {8'd0, bits};
    total = {1'b0, fill_q} + {1'b0, n};
    done  = (total >= 4'd8);
    rem   = done ? 3'(total - 4'd8) : total[2:0];
    cbyte = 8'(wide >> rem);
    acc_n = done ? (wide[7:0] & 8'((9'd1 << rem) - 9'd1)) : wide[7:0];
    fill_n = rem;
    pad      = is_flush && (fill_n != 3'd0);
    pad_byte = 8'(acc_n << (4'd8 - {1'b0, fill_n}));
  end

  always_comb begin
    job_o.flush  = is_flush;
    job_o.data0  = done ? cbyte : pad_byte;
    job_o.data1  = pad_byte;
    job_o.nbytes = {1'b0, done} + {1'b0, pad};
    acc_d        = is_flush ? 8'd0 : acc_n;
    fill_d       = is_flush ? 3'd0 : fill_n;
  end

  assign push_o = accept && (is_flush || done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 4'd0;
      run_q  <= 3'd0;
      acc_q  <= 8'd0;
      fill_q <= 3'd0;
    end else if (accept) begin
      idx_q  <= idx_d;
      run_q  <= run_d;
      acc_q  <= acc_d;
      fill_q <= fill_d;
    end
  end

endmodule

[hw/rtl/mel_rle_fifo.sv]
// Short job queue between packer and byte stage.
// Depends on mel_rle_pkg.
module mel_rle_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mel_rle_pkg::job_t job_i,
  output logic              full_o,
  output logic              head_valid_o,
  output mel_rle_pkg::job_t head_o,
  input  logic              pop_i
);

  mel_rle_pkg::job_t entries_q [mel_rle_pkg::QueueDepth];

  logic [mel_rle_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [mel_rle_pkg::QCntW-1:0] cnt_q;

  assign full_o       = (cnt_q == mel_rle_pkg::QCntW'(mel_rle_pkg::QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[hw/rtl/mel_rle_back.sv]
// Byte stage of the MEL encoder: byte limit, overflow, block count, output register.
// Depends on mel_rle_pkg.
module mel_rle_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                head_valid_i,
  input  mel_rle_pkg::job_t                   head_i,
  output logic                                pop_o,
  input  logic [mel_rle_pkg::CountW-1:0]      max_bytes_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output mel_rle_pkg::out_item_t              out_item_o
);

  logic                           sub_q;
  logic [mel_rle_pkg::CountW-1:0] bw_q, bw_n;
  logic                           ovf_q, ovf_n;
  logic                           out_valid_q;
  mel_rle_pkg::out_item_t         out_q;

  logic       adv;
  logic [7:0] cur;
  logic       have;
  logic       tail;
  logic       blk_end;
  logic       pair_first;
  logic       emit;
  logic       has;
  logic [7:0] data;
  logic       last;

  assign adv = head_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    cur        = sub_q ? head_i.data1 : head_i.data0;
    have       = (head_i.nbytes > {1'b0, sub_q});
    tail       = sub_q || (head_i.nbytes <= 2'd1);
    blk_end    = head_i.flush && tail;
    pair_first = head_i.flush && !tail;
    emit = 1'b0;
    has  = 1'b0;
    data = 8'd0;
    bw_n = bw_q;
    ovf_n = ovf_q;
    if (have && !ovf_q) begin
      emit = 1'b1;
      if (bw_q < max_bytes_i) begin
        has  = 1'b1;
        data = cur;
        bw_n = bw_q + 1'b1;
      end else begin
        ovf_n = 1'b1;
      end
    end
    // an overflow on the first of two flush bytes ends the block there
    last = blk_end || (pair_first && ovf_n && !ovf_q);
    if (blk_end) begin
      emit = 1'b1;
    end
  end

  assign pop_o = adv && (tail || last);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.data_byte   <= data;
      out_q.has_byte    <= has;
      out_q.is_last     <= last;
      out_q.overflow    <= ovf_n;
      out_q.total_bytes <= last ? bw_n : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= 1'b0;
      bw_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= head_valid_i && emit;
      end
      if (adv) begin
        sub_q <= !pop_o;
        if (last) begin
          bw_q  <= '0;
          ovf_q <= 1'b0;
        end else begin
          bw_q  <= bw_n;
          ovf_q <= ovf_n;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[hw/rtl/mel_rle_checker.sv]
// Port-level checker for the MEL run-length encoder, bound to the top level.
// Depends on mel_rle_pkg and mel_run_length_encoder_core_macros.svh.
`include "mel_run_length_encoder_core_macros.svh"

module mel_rle_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input mel_rle_pkg::out_item_t         out_item_o
);

  `MEL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_item_o), "stalled result changed")

  `MEL_ASSERT_IMP(a_total_on_last, clk_i, rst_ni, out_valid_o && !out_item_o.is_last,
    out_item_o.total_bytes == '0, "byte count outside block end")

  `MEL_ASSERT_IMP(a_empty_byte, clk_i, rst_ni, out_valid_o && !out_item_o.has_byte,
    out_item_o.data_byte == 8'd0, "data on a result without byte")

  `MEL_ASSERT_IMP(a_empty_is_ovf, clk_i, rst_ni,
    out_valid_o && !out_item_o.has_byte && !out_item_o.is_last,
    out_item_o.overflow, "empty result that is neither end nor overflow")

endmodule

bind mel_run_length_encoder_core mel_rle_checker u_checker (.*);

[test/tb_mel_run_length_encoder_core.sv]
// Self-checking testbench for mel_run_length_encoder_core: a directed table and then
// random blocks of significance symbols, each checked against an in-bench MEL coder.
// Depends on mel_rle_pkg and the RTL of the encoder.
module tb_mel_run_length_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 11;
  localparam int IdlePct      = 7;
  localparam int RandomItems  = 1750;
  localparam int SettleCycles = 8;     // packer, job queue and byte stage
  localparam int StuckLimit   = 4000;  // cycles with no handshake at all
  localparam int QuietFrom    = 500;
  localparam int QuietTo      = 900;

  typedef enum logic {RowItem, RowCap} row_kind_e;

  // one line of the directed table; typed rows carry their own expectation
  typedef struct packed {
    row_kind_e                      kind;
    mel_rle_pkg::in_item_t          item;
    logic [mel_rle_pkg::CountW-1:0] cap_val;
    logic                           typed;
    logic [1:0]                     n_typed;
    mel_rle_pkg::out_item_t         typed_res;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid  = 1'b0;
  mel_rle_pkg::in_item_t          in_item   = '0;
  logic                           in_stall;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  mel_rle_pkg::out_item_t         out_item;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mel_rle_pkg::CountW-1:0] cfg_data  = '0;

  // no idling on either side while set
  logic quiet = 1'b0;

  int unsigned mismatches  = 0;
  int unsigned stuck_cycles = 0;

  mel_rle_pkg::out_item_t expected_q[$];

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  mel_run_length_encoder_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // MEL coder model: state, byte capacity and the results of the current item
  // ---------------------------------------------------------------------------
  int                             exp_of_index [9] = '{0, 0, 0, 1, 1, 2, 2, 3, 3};
  int                             mel_idx;
  logic [2:0]                     run_len;
  logic [7:0]                     acc;
  int                             fill;
  logic [mel_rle_pkg::CountW-1:0] written;
  logic                           ovf_seen;
  logic [mel_rle_pkg::CountW-1:0] byte_cap = mel_rle_pkg::MaxBytesReset;

  logic [7:0]             done_byte [2];
  int                     n_done;
  mel_rle_pkg::out_item_t res_buf [2];
  int                     n_res;

  task automatic clear_coder();
    mel_idx  = 0;
    run_len  = '0;
    acc      = '0;
    fill     = 0;
    written  = '0;
    ovf_seen = 1'b0;
  endtask

  // bits go in MSB first; a full byte is parked until committed
  task automatic append_bit(input logic b);
    acc  = {acc[6:0], b};
    fill = fill + 1;
    if (fill == 8) begin
      if (n_done < 2) begin
        done_byte[n_done] = acc;
        n_done++;
      end
      acc  = '0;
      fill = 0;
    end
  endtask

  // end of a run: a 0 and then the run length in K bits
  task automatic append_run();
    int k;
    k = exp_of_index[mel_idx];
    append_bit(1'b0);
    for (int j = k - 1; j >= 0; j--) append_bit(run_len[j]);
  endtask

  // the byte limit applies to every completed byte, padding byte included
  task automatic commit_bytes();
    for (int j = 0; j < n_done; j++) begin
      if (!ovf_seen) begin
        res_buf[n_res] = '0;
        if (written < byte_cap) begin
          res_buf[n_res].data_byte = done_byte[j];
          res_buf[n_res].has_byte  = 1'b1;
          written = written + 1'b1;
        end else begin
          ovf_seen = 1'b1;
        end
        res_buf[n_res].overflow = ovf_seen;
        n_res++;
      end
    end
  endtask

  task automatic encode_item(input mel_rle_pkg::in_item_t it);
    n_done = 0;
    n_res  = 0;
    if (it.req_type == mel_rle_pkg::ReqSymbol) begin
      // symbols are dropped once the block has overflowed
      if (ovf_seen) return;
      if (it.sig == 1'b0) begin
        run_len = run_len + 3'd1;
        if (run_len == 3'(1 << exp_of_index[mel_idx])) begin
          append_bit(1'b1);
          run_len = '0;
          if (mel_idx < 8) mel_idx++;
        end
      end else begin
        append_run();
        run_len = '0;
        if (mel_idx > 0) mel_idx--;
      end
      commit_bytes();
    end else begin
      if (!ovf_seen) begin
        if (run_len != '0) append_run();
        if (fill > 0 && n_done < 2) begin
          done_byte[n_done] = acc << (8 - fill);
          n_done++;
        end
        acc  = '0;
        fill = 0;
        commit_bytes();
      end
      // a flush always ends with the marker, bare if no byte goes with it
      if (n_res == 0) begin
        res_buf[0] = '0;
        n_res = 1;
      end
      res_buf[n_res-1].overflow    = ovf_seen;
      res_buf[n_res-1].is_last     = 1'b1;
      res_buf[n_res-1].total_bytes = written;
      clear_coder();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_result(input mel_rle_pkg::out_item_t want,
                              input mel_rle_pkg::out_item_t got);
    if (got.data_byte !== want.data_byte) begin
      $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
      mismatches++;
    end
    if (got.has_byte !== want.has_byte) begin
      $error("has_byte: expected %0b, got %0b", want.has_byte, got.has_byte);
      mismatches++;
    end
    if (got.is_last !== want.is_last) begin
      $error("is_last: expected %0b, got %0b", want.is_last, got.is_last);
      mismatches++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
      mismatches++;
    end
    if (got.total_bytes !== want.total_bytes) begin
      $error("total_bytes: expected %0d, got %0d", want.total_bytes, got.total_bytes);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    mel_rle_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: byte %0h, last %0b", out_item.data_byte, out_item.is_last);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_result(want, out_item);
      end
    end
  end

  // receiver stalls at random, except in the quiet window
  always @(posedge clk_i) begin
    out_stall <= rst_n && !quiet && ($urandom_range(99) < IdlePct);
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
        $error("no handshake for %0d cycles, %0d results outstanding",
               StuckLimit, expected_q.size());
        $display("FAILURE");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // let every outstanding result arrive, then allow for symbols with no result
  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cap(input logic [mel_rle_pkg::CountW-1:0] v);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    byte_cap = v;
  endtask

  // hand one item over; typed rows replace the predicted results with their own
  task automatic send_item(input mel_rle_pkg::in_item_t it, input logic typed,
                           input logic [1:0] n_typed,
                           input mel_rle_pkg::out_item_t typed_res);
    if (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    encode_item(it);
    if (typed) begin
      if (n_typed != 0) expected_q.push_back(typed_res);
    end else begin
      for (int j = 0; j < n_res; j++) expected_q.push_back(res_buf[j]);
    end
  endtask

  function automatic plan_row_t item_row(input logic req, input logic sig);
    plan_row_t r;
    r = '0;
    r.kind          = RowItem;
    r.item.req_type = req;
    r.item.sig      = sig;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic req, input logic sig, input logic [1:0] n,
                                          input mel_rle_pkg::out_item_t e);
    plan_row_t r;
    r = item_row(req, sig);
    r.typed     = 1'b1;
    r.n_typed   = n;
    r.typed_res = e;
    return r;
  endfunction

  function automatic plan_row_t cap_row(input logic [mel_rle_pkg::CountW-1:0] v);
    plan_row_t r;
    r = '0;
    r.kind    = RowCap;
    r.cap_val = v;
    return r;
  endfunction

  function automatic logic [mel_rle_pkg::CountW-1:0] pick_cap();
    case ($urandom_range(7))
      0:       return '0;
      1:       return mel_rle_pkg::MaxBytesReset;
      2:       return mel_rle_pkg::CountW'($urandom_range(3));
      3:       return mel_rle_pkg::CountW'($urandom_range(12, 4));
      4:       return mel_rle_pkg::CountW'($urandom);
      default: return mel_rle_pkg::MaxBytesReset;
    endcase
  endfunction

  plan_row_t plan[$];

  task automatic run_directed();
    mel_rle_pkg::out_item_t none;
    none = '0;
    plan = '{
      // empty block: bare end marker
      typed_row(mel_rle_pkg::ReqFlush,  1'b0, 2'd1, {8'h00, 1'b0, 1'b1, 1'b0, 24'd0}),
      // zero at index 0 puts a single 1, no byte yet
      typed_row(mel_rle_pkg::ReqSymbol, 1'b0, 2'd0, none),
      item_row(mel_rle_pkg::ReqSymbol, 1'b0), item_row(mel_rle_pkg::ReqSymbol, 1'b0),
      item_row(mel_rle_pkg::ReqSymbol, 1'b0), item_row(mel_rle_pkg::ReqSymbol, 1'b0),
      item_row(mel_rle_pkg::ReqSymbol, 1'b0),
      item_row(mel_rle_pkg::ReqSymbol, 1'b1), item_row(mel_rle_pkg::ReqSymbol, 1'b1),
      // flush with sig set: sig is ignored, partial byte padded
      item_row(mel_rle_pkg::ReqFlush,  1'b1),
      // zero capacity: the first full byte overflows
      cap_row('0),
      typed_row(mel_rle_pkg::ReqSymbol, 1'b1, 2'd0, none),
      typed_row(mel_rle_pkg::ReqSymbol, 1'b1, 2'd0, none),
      typed_row(mel_rle_pkg::ReqSymbol, 1'b1, 2'd0, none),
      typed_row(mel_rle_pkg::ReqSymbol, 1'b1, 2'd0, none),
      typed_row(mel_rle_pkg::ReqSymbol, 1'b1, 2'd0, none),
      typed_row(mel_rle_pkg::ReqSymbol, 1'b1, 2'd0, none),
      typed_row(mel_rle_pkg::ReqSymbol, 1'b1, 2'd0, none),
      typed_row(mel_rle_pkg::ReqSymbol, 1'b1, 2'd1, {8'h00, 1'b0, 1'b0, 1'b1, 24'd0}),
      // after overflow symbols vanish, and the flush is only the marker
      typed_row(mel_rle_pkg::ReqSymbol, 1'b0, 2'd0, none),
      typed_row(mel_rle_pkg::ReqFlush,  1'b0, 2'd1, {8'h00, 1'b0, 1'b1, 1'b1, 24'd0}),
      // one-byte capacity: padding byte just fits
      cap_row(24'd1),
      item_row(mel_rle_pkg::ReqSymbol, 1'b1), item_row(mel_rle_pkg::ReqSymbol, 1'b1),
      item_row(mel_rle_pkg::ReqSymbol, 1'b1),
      item_row(mel_rle_pkg::ReqSymbol, 1'b0),
      item_row(mel_rle_pkg::ReqFlush,  1'b1)
    };
    foreach (plan[i]) begin
      if (plan[i].kind == RowCap) begin
        write_cap(plan[i].cap_val);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].n_typed, plan[i].typed_res);
      end
    end
  endtask

  // random blocks: mostly symbol runs closed by a flush, with stray flushes
  // mixed in; capacity changes between blocks once the encoder is idle
  task automatic run_random();
    int                    sent;
    int                    blk;
    int                    len;
    int                    p_one;
    mel_rle_pkg::in_item_t it;
    sent = 0;
    blk  = 0;
    while (sent < RandomItems) begin
      if (blk % 6 == 0) begin
        write_cap(pick_cap());
      end else if ($urandom_range(9) == 0) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      quiet = (sent >= QuietFrom && sent < QuietTo);
      len = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(30);
      case ($urandom_range(3))
        0:       p_one = 5;
        1:       p_one = 30;
        2:       p_one = 50;
        default: p_one = 85;
      endcase
      for (int j = 0; j < len; j++) begin
        it.req_type = ($urandom_range(49) == 0) ? mel_rle_pkg::ReqFlush : mel_rle_pkg::ReqSymbol;
        it.sig      = ($urandom_range(99) < p_one);
        sent++;
        send_item(it, 1'b0, 2'd0, '0);
      end
      it.req_type = mel_rle_pkg::ReqFlush;
      it.sig      = 1'($urandom_range(1));
      send_item(it, 1'b0, 2'd0, '0);
      sent++;
      blk++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    clear_coder();
    repeat (ResetCycles) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random();
    write_cap(mel_rle_pkg::MaxBytesReset);

    in_valid <= 1'b0;
    wait_drained();
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/mel_rle_pkg.sv
hw/rtl/mel_rle_front.sv
hw/rtl/mel_rle_fifo.sv
hw/rtl/mel_rle_back.sv
hw/rtl/mel_run_length_encoder_core.sv
hw/rtl/mel_rle_checker.sv
test/tb_mel_run_length_encoder_core.sv
